// ===== rtl/core/dense_layer_forward_unit_macros.svh =====
// assertion macros for the dense layer unit
`ifndef DENSE_LAYER_FORWARD_UNIT_MACROS_SVH
`define DENSE_LAYER_FORWARD_UNIT_MACROS_SVH

// same-cycle implication
`define DLF_ASSERT_NOW(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define DLF_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/core/dlf_pkg.sv =====
// shared constants, codes and lookup tables of the dense layer unit
package dlf_pkg;

  localparam int OPCODE_W   = 2;
  localparam int NEURON_W   = 7;
  localparam int POS_W      = 10;
  localparam int IN_CNT_W   = 11;
  localparam int OUT_CNT_W  = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 11;
  localparam int ACC_W      = 40;
  localparam int EXP_W      = 17;
  localparam int SIG_W      = 13;

  localparam logic [OPCODE_W-1:0] OP_WEIGHT = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_BIAS   = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_ACT    = 2'd2;
  localparam logic [OPCODE_W-1:0] OP_READ   = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_SOFTMAX   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IN_COUNT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_COUNT = 2'd2;

  localparam logic [IN_CNT_W-1:0]  IN_COUNT_RST  = 11'd784;
  localparam logic [OUT_CNT_W-1:0] OUT_COUNT_RST = 8'd128;

  // sigmoid(k/4) in Q.12
  function automatic logic [11:0] sig_tab(input logic [5:0] k);
    logic [11:0] v;
    case (k)
      6'd0:  v = 12'd2048;  6'd1:  v = 12'd2303;  6'd2:  v = 12'd2550;
      6'd3:  v = 12'd2782;  6'd4:  v = 12'd2994;  6'd5:  v = 12'd3184;
      6'd6:  v = 12'd3349;  6'd7:  v = 12'd3490;  6'd8:  v = 12'd3608;
      6'd9:  v = 12'd3705;  6'd10: v = 12'd3785;  6'd11: v = 12'd3850;
      6'd12: v = 12'd3902;  6'd13: v = 12'd3943;  6'd14: v = 12'd3976;
      6'd15: v = 12'd4002;  6'd16: v = 12'd4022;  6'd17: v = 12'd4038;
      6'd18: v = 12'd4051;  6'd19: v = 12'd4061;  6'd20: v = 12'd4069;
      6'd21: v = 12'd4075;  6'd22: v = 12'd4079;  6'd23: v = 12'd4083;
      6'd24: v = 12'd4086;  6'd25: v = 12'd4088;  6'd26: v = 12'd4090;
      6'd27: v = 12'd4091;  6'd28: v = 12'd4092;  6'd29: v = 12'd4093;
      6'd30: v = 12'd4094;  6'd31: v = 12'd4094;
      default: v = 12'd4095;
    endcase
    return v;
  endfunction

  // exp(-k/2) in Q.16
  function automatic logic [EXP_W-1:0] exp_tab(input logic [5:0] k);
    logic [EXP_W-1:0] v;
    case (k)
      6'd0:  v = 17'd65536; 6'd1:  v = 17'd39750; 6'd2:  v = 17'd24109;
      6'd3:  v = 17'd14623; 6'd4:  v = 17'd8869;  6'd5:  v = 17'd5380;
      6'd6:  v = 17'd3263;  6'd7:  v = 17'd1979;  6'd8:  v = 17'd1200;
      6'd9:  v = 17'd728;   6'd10: v = 17'd442;   6'd11: v = 17'd268;
      6'd12: v = 17'd162;   6'd13: v = 17'd99;    6'd14: v = 17'd60;
      6'd15: v = 17'd36;    6'd16: v = 17'd22;    6'd17: v = 17'd13;
      6'd18: v = 17'd8;     6'd19: v = 17'd5;     6'd20: v = 17'd3;
      6'd21: v = 17'd2;     6'd22: v = 17'd1;     6'd23: v = 17'd1;
      default: v = 17'd0;
    endcase
    return v;
  endfunction

endpackage

// ===== rtl/core/dense_layer_forward_unit.sv =====
// top level of the dense layer unit: sequencer, memories and datapath
// Input channel (in_valid/in_stall) carries weight, bias, activation and read
// items; the user must write configuration through cfg_we/cfg_index/cfg_data
// only while idle, which the unit does not enforce. Weight, bias and activation
// items give no result and, but for a final one, do not stall. A read item
// gives one result on the output channel (out_valid/out_stall) through
// rd_pending and the output register. An activation item marked final starts
// the layer if the output count is not zero: per neuron S_BIAS and S_BINIT
// load the bias, S_MAC takes one input per cycle through the single
// weight/input read port and multiplier, then S_CONV and S_STORE convert and
// store. Sigmoid adds no state; softmax adds per neuron S_EXP_RD, S_EXP_CALC
// and S_EXP_SUM for the sum and S_DIV_RD, S_DIV_EXP, S_DIV_GO and S_DIV_WAIT
// around the divider. No item is taken until the layer is done. Reset clears
// the sequencer and output valid bits and loads the default configuration, so
// outputs read as zero until computed; weight, bias and input memories are
// undefined until written. A stalled result holds and blocks further items.
module dense_layer_forward_unit #(
  parameter int MAX_INPUTS  = 1024,
  parameter int MAX_OUTPUTS = 128,
  parameter int VALUE_WIDTH = 16
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [dlf_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [dlf_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [dlf_pkg::OPCODE_W-1:0]     opcode,
  input  logic [dlf_pkg::NEURON_W-1:0]     neuron,
  input  logic [dlf_pkg::POS_W-1:0]        position,
  input  logic signed [VALUE_WIDTH-1:0]    datum,
  input  logic                             final_input,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [dlf_pkg::NEURON_W-1:0]     out_index,
  output logic signed [VALUE_WIDTH-1:0]    activation
);
  import dlf_pkg::*;

  `include "dense_layer_forward_unit_macros.svh"

  localparam int VW    = VALUE_WIDTH;
  localparam int IW    = $clog2(MAX_INPUTS);
  localparam int OW    = $clog2(MAX_OUTPUTS);
  localparam int CI_W  = $clog2(MAX_INPUTS + 1);
  localparam int CO_W  = $clog2(MAX_OUTPUTS + 1);
  localparam int WDEP  = MAX_OUTPUTS * MAX_INPUTS;
  localparam int WAW   = $clog2(WDEP);
  localparam int SW    = ((2 * VW > ACC_W) ? 2 * VW : ACC_W) + 1;
  localparam int SUM_W = EXP_W + OW;
  localparam int NUM_W = ((16 + OW > 29) ? 16 + OW : 29) + 1;
  localparam logic signed [SW-1:0] SAT_HI = {{(SW-ACC_W+1){1'b0}}, {(ACC_W-1){1'b1}}};
  localparam logic signed [SW-1:0] SAT_LO = {{(SW-ACC_W+1){1'b1}}, {(ACC_W-1){1'b0}}};
  localparam logic signed [63:0] V_HI = (64'sd1 <<< (VW - 1)) - 64'sd1;
  localparam logic signed [63:0] V_LO = -V_HI - 64'sd1;

  typedef enum logic [3:0] {
    S_IDLE, S_BIAS, S_BINIT, S_MAC, S_CONV, S_STORE,
    S_EXP_RD, S_EXP_CALC, S_EXP_SUM, S_DIV_RD, S_DIV_EXP, S_DIV_GO, S_DIV_WAIT
  } state_t;

  state_t state;

  logic softmax_mode;
  logic [IN_CNT_W-1:0]  input_count;
  logic [OUT_CNT_W-1:0] output_count;

  logic [CI_W-1:0] n_in, i;
  logic [CO_W-1:0] n_out, j;
  logic [WAW-1:0] row_base;
  logic v1, v2, rd_pending, rd_ok, last_j;
  logic [NEURON_W-1:0] rd_index;
  logic signed [2*VW-1:0] prod;
  logic signed [ACC_W-1:0] acc, acc_mac, acc_bias;
  logic signed [VW-1:0] net_reg, top, net_conv;
  logic [EXP_W-1:0] e_reg, act_e;
  logic [SUM_W-1:0] sum;
  logic [MAX_OUTPUTS-1:0] out_ok;

  logic in_xfer, nrn_ok, pos_ok, issue;
  logic [VW-1:0] w_rdata, x_rdata, b_rdata, n_rdata, o_rdata;
  logic o_we;
  logic [VW-1:0] o_wdata;
  logic signed [VW-1:0] act_sig;
  logic signed [VW:0] tdiff;
  logic div_start, div_done;
  logic [NUM_W-1:0] div_q, div_num;

  function automatic logic signed [ACC_W-1:0] sat_acc(input logic signed [SW-1:0] s);
    logic signed [ACC_W-1:0] r;
    if (s > SAT_HI) begin
      r = SAT_HI[ACC_W-1:0];
    end else if (s < SAT_LO) begin
      r = SAT_LO[ACC_W-1:0];
    end else begin
      r = s[ACC_W-1:0];
    end
    return r;
  endfunction

  always_comb begin
    logic signed [ACC_W:0] rnd;
    logic signed [63:0] qx;
    n_in  = (32'(input_count) > MAX_INPUTS) ? CI_W'(MAX_INPUTS) : CI_W'(input_count);
    n_out = (32'(output_count) > MAX_OUTPUTS) ? CO_W'(MAX_OUTPUTS) : CO_W'(output_count);
    last_j = (j == n_out - CO_W'(1));
    in_stall = (state != S_IDLE) | rd_pending | (out_valid & out_stall);
    in_xfer  = in_valid & ~in_stall;
    nrn_ok   = 32'(neuron) < MAX_OUTPUTS;
    pos_ok   = 32'(position) < MAX_INPUTS;
    issue    = (state == S_MAC) && (i < n_in);
    acc_mac  = sat_acc(SW'(acc) + SW'(prod));
    acc_bias = sat_acc(SW'($signed(b_rdata)) <<< 12);
    rnd      = (ACC_W+1)'(acc) + (ACC_W+1)'(2048);
    qx       = 64'($signed(rnd[ACC_W:12]));
    net_conv = (qx > V_HI) ? VW'(V_HI) : (qx < V_LO) ? VW'(V_LO) : VW'(qx);
    tdiff    = (VW+1)'(top) - (VW+1)'($signed(n_rdata));
    div_start = (state == S_DIV_GO);
    div_num  = (NUM_W'(e_reg) << 12) + NUM_W'(sum >> 1);
    o_we     = ((state == S_STORE) && !softmax_mode) || ((state == S_DIV_WAIT) && div_done);
    o_wdata  = (state == S_STORE) ? act_sig : VW'(div_q);
  end

  dlf_ram #(.WIDTH(VW), .DEPTH(WDEP)) u_weight (
    .clk(clk),
    .we(in_xfer && opcode == OP_WEIGHT && nrn_ok && pos_ok),
    .waddr(WAW'(32'(neuron) * MAX_INPUTS + 32'(position))),
    .wdata(datum),
    .raddr(row_base + WAW'(i)),
    .rdata(w_rdata)
  );

  dlf_ram #(.WIDTH(VW), .DEPTH(MAX_INPUTS)) u_input (
    .clk(clk),
    .we(in_xfer && opcode == OP_ACT && pos_ok),
    .waddr(IW'(position)),
    .wdata(datum),
    .raddr(i[IW-1:0]),
    .rdata(x_rdata)
  );

  dlf_ram #(.WIDTH(VW), .DEPTH(MAX_OUTPUTS)) u_bias (
    .clk(clk),
    .we(in_xfer && opcode == OP_BIAS && nrn_ok),
    .waddr(OW'(neuron)),
    .wdata(datum),
    .raddr(j[OW-1:0]),
    .rdata(b_rdata)
  );

  dlf_ram #(.WIDTH(VW), .DEPTH(MAX_OUTPUTS)) u_net (
    .clk(clk),
    .we(state == S_STORE),
    .waddr(j[OW-1:0]),
    .wdata(net_reg),
    .raddr(j[OW-1:0]),
    .rdata(n_rdata)
  );

  dlf_ram #(.WIDTH(VW), .DEPTH(MAX_OUTPUTS)) u_out (
    .clk(clk),
    .we(o_we),
    .waddr(j[OW-1:0]),
    .wdata(o_wdata),
    .raddr(OW'(neuron)),
    .rdata(o_rdata)
  );

  dlf_act #(.VALUE_WIDTH(VW)) u_act (
    .z(net_reg),
    .t($unsigned(tdiff)),
    .sig(act_sig),
    .expo(act_e)
  );

  dlf_div #(.NUM_W(NUM_W), .DEN_W(SUM_W)) u_div (
    .clk(clk),
    .rst(rst),
    .start(div_start),
    .num(div_num),
    .den(sum),
    .done(div_done),
    .quot(div_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      softmax_mode <= 1'b0;
      input_count  <= IN_COUNT_RST;
      output_count <= OUT_COUNT_RST;
      out_ok       <= '0;
      out_valid    <= 1'b0;
      rd_pending   <= 1'b0;
      v1           <= 1'b0;
      v2           <= 1'b0;
      i            <= '0;
      j            <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_SOFTMAX:   softmax_mode <= cfg_data[0];
          REG_IN_COUNT:  input_count  <= cfg_data[IN_CNT_W-1:0];
          REG_OUT_COUNT: output_count <= cfg_data[OUT_CNT_W-1:0];
          default: ;
        endcase
      end

      // read path
      rd_pending <= in_xfer && opcode == OP_READ;
      if (in_xfer && opcode == OP_READ) begin
        rd_index <= neuron;
        rd_ok    <= nrn_ok && out_ok[OW'(neuron)];
      end
      if (rd_pending) begin
        out_valid  <= 1'b1;
        out_index  <= rd_index;
        activation <= rd_ok ? $signed(o_rdata) : '0;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end

      if (o_we) begin
        out_ok[j[OW-1:0]] <= 1'b1;
      end

      // mac pipeline
      v1 <= issue;
      v2 <= v1;
      if (issue) begin
        i <= i + 1'b1;
      end
      if (v1) begin
        prod <= $signed(w_rdata) * $signed(x_rdata);
      end

      case (state)
        S_IDLE: begin
          j        <= '0;
          row_base <= '0;
          if (in_xfer && opcode == OP_ACT && final_input && n_out != '0) begin
            state <= S_BIAS;
          end
        end
        S_BIAS: state <= S_BINIT;
        S_BINIT: begin
          acc   <= acc_bias;
          i     <= '0;
          state <= S_MAC;
        end
        S_MAC: begin
          if (v2) begin
            acc <= acc_mac;
          end
          if (!issue && !v1 && !v2) begin
            state <= S_CONV;
          end
        end
        S_CONV: begin
          net_reg <= net_conv;
          state   <= S_STORE;
        end
        S_STORE: begin
          if (j == '0 || net_reg > top) begin
            top <= net_reg;
          end
          row_base <= row_base + WAW'(MAX_INPUTS);
          if (last_j) begin
            j     <= '0;
            sum   <= '0;
            state <= softmax_mode ? S_EXP_RD : S_IDLE;
          end else begin
            j     <= j + 1'b1;
            state <= S_BIAS;
          end
        end
        S_EXP_RD: state <= S_EXP_CALC;
        S_EXP_CALC: begin
          e_reg <= act_e;
          state <= S_EXP_SUM;
        end
        S_EXP_SUM: begin
          sum <= sum + SUM_W'(e_reg);
          if (last_j) begin
            j     <= '0;
            state <= S_DIV_RD;
          end else begin
            j     <= j + 1'b1;
            state <= S_EXP_RD;
          end
        end
        S_DIV_RD: state <= S_DIV_EXP;
        S_DIV_EXP: begin
          e_reg <= act_e;
          state <= S_DIV_GO;
        end
        S_DIV_GO: state <= S_DIV_WAIT;
        S_DIV_WAIT: begin
          if (div_done) begin
            if (last_j) begin
              state <= S_IDLE;
            end else begin
              j     <= j + 1'b1;
              state <= S_DIV_RD;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `DLF_ASSERT_NEXT(a_read_lands, clk, rst, rd_pending, out_valid, "read data lost")
  `DLF_ASSERT_NOW(a_mac_drained, clk, rst, state == S_CONV, !v1 && !v2, "mac pipe not drained")
  `DLF_ASSERT_NOW(a_div_owner, clk, rst, div_done, state == S_DIV_WAIT, "stray divider result")
endmodule

// ===== rtl/core/dlf_ram.sv =====
// generic simple dual-port ram with registered read
module dlf_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== rtl/core/dlf_act.sv =====
// sigmoid and negative exponential by table with linear interpolation
module dlf_act #(
  parameter int VALUE_WIDTH = 16
) (
  input  logic signed [VALUE_WIDTH-1:0]   z,
  input  logic        [VALUE_WIDTH:0]     t,
  output logic signed [VALUE_WIDTH-1:0]   sig,
  output logic        [dlf_pkg::EXP_W-1:0] expo
);
  import dlf_pkg::*;

  logic signed [VALUE_WIDTH:0] zx;
  logic [VALUE_WIDTH:0] mag;
  logic [31:0] a32, t32, y, sv;
  logic [5:0] sidx, eidx;
  logic [11:0] s0, s1;
  logic [EXP_W-1:0] e0, e1;
  logic [31:0] sprod, eprod;

  always_comb begin
    zx    = (VALUE_WIDTH+1)'(z);
    mag   = zx[VALUE_WIDTH] ? $unsigned(-zx) : $unsigned(zx);
    a32   = 32'(mag);
    sidx  = {1'b0, a32[14:10]};
    s0    = sig_tab(sidx);
    s1    = sig_tab(sidx + 6'd1);
    sprod = 32'(s1 - s0) * 32'(a32[9:0]) + 32'd512;
    if (a32 >= 32'd32768) begin
      y = 32'(sig_tab(6'd32));
    end else begin
      y = 32'(s0) + (sprod >> 10);
    end
    sv  = zx[VALUE_WIDTH] ? (32'd4096 - y) : y;
    sig = VALUE_WIDTH'(sv);

    t32   = 32'(t);
    eidx  = {1'b0, t32[15:11]};
    e0    = exp_tab(eidx);
    e1    = exp_tab(eidx + 6'd1);
    eprod = 32'(e0 - e1) * 32'(t32[10:0]) + 32'd1024;
    if (t32 >= 32'd65536) begin
      expo = '0;
    end else begin
      expo = e0 - EXP_W'(eprod >> 11);
    end
  end
endmodule

// ===== rtl/core/dlf_div.sv =====
// restoring divider, one quotient bit per cycle
module dlf_div #(
  parameter int NUM_W = 30,
  parameter int DEN_W = 24
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [NUM_W-1:0] quot
);
  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [DEN_W-1:0] rem, dsor;
  logic [CNT_W-1:0] cnt;
  logic busy;
  logic [DEN_W:0] trial;
  logic take;

  always_comb begin
    trial = {rem, quot[NUM_W-1]};
    take  = trial >= {1'b0, dsor};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(NUM_W);
        quot <= num;
        rem  <= '0;
        dsor <= den;
      end else if (busy) begin
        rem  <= take ? DEN_W'(trial - {1'b0, dsor}) : trial[DEN_W-1:0];
        quot <= {quot[NUM_W-2:0], take};
        cnt  <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

// ===== bench/dense_layer_forward_unit_tb.sv =====
// testbench for the dense layer unit: directed and random items checked against a predictor
`timescale 1ns / 100ps

module dense_layer_forward_unit_tb;
  import dlf_pkg::*;

  localparam int NIN = 1024;
  localparam int NOUT = 128;
  localparam int WATCH_LIMIT = 200000;
  localparam int TARGET_ITEMS = 1900;

  typedef struct {
    logic [NEURON_W-1:0] idx;
    logic signed [15:0] act;
  } readout_t;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic in_valid;
  logic in_stall;
  logic [OPCODE_W-1:0] opcode;
  logic [NEURON_W-1:0] neuron;
  logic [POS_W-1:0] position;
  logic signed [15:0] datum;
  logic final_input;
  logic out_valid;
  logic out_stall;
  logic [NEURON_W-1:0] out_index;
  logic signed [15:0] activation;

  dense_layer_forward_unit dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .opcode(opcode), .neuron(neuron),
    .position(position), .datum(datum), .final_input(final_input),
    .out_valid(out_valid), .out_stall(out_stall), .out_index(out_index),
    .activation(activation)
  );

  int sig_lut[33] = '{
    2048, 2303, 2550, 2782, 2994, 3184, 3349, 3490, 3608, 3705, 3785,
    3850, 3902, 3943, 3976, 4002, 4022, 4038, 4051, 4061, 4069, 4075,
    4079, 4083, 4086, 4088, 4090, 4091, 4092, 4093, 4094, 4094, 4095};
  int exp_lut[33] = '{
    65536, 39750, 24109, 14623, 8869, 5380, 3263, 1979, 1200, 728, 442,
    268, 162, 99, 60, 36, 22, 13, 8, 5, 3, 2, 1, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0};

  bit softmax_on;
  int in_cnt;
  int out_cnt;
  shortint weights[NIN*NOUT];
  bit weight_set[NIN*NOUT];
  shortint biases[NOUT];
  bit bias_set[NOUT];
  shortint inputs[NIN];
  bit input_set[NIN];
  shortint outputs[NOUT];
  longint net[NOUT];
  int expo[NOUT];

  readout_t pending_reads[$];
  int errors;
  int items_sent;
  bit no_idle;
  int out_hold;
  int quiet_cycles;

  always #2 clk = ~clk;

  function automatic longint sat_acc(longint a);
    longint hi;
    hi = (64'sd1 <<< 39) - 1;
    if (a > hi) return hi;
    if (a < -hi - 1) return -hi - 1;
    return a;
  endfunction

  function automatic int to_q12(longint acc);
    longint q;
    q = (acc + 2048) >>> 12;
    if (q > 32767) return 32767;
    if (q < -32768) return -32768;
    return int'(q);
  endfunction

  function automatic int sigmoid_q12(int z);
    int a;
    int y;
    int k;
    a = z < 0 ? -z : z;
    if (a >= 32768) y = sig_lut[32];
    else begin
      k = a >> 10;
      y = sig_lut[k] + (((sig_lut[k+1] - sig_lut[k]) * (a & 1023) + 512) >> 10);
    end
    return z < 0 ? 4096 - y : y;
  endfunction

  function automatic int exp_neg_q16(longint t);
    int k;
    longint d;
    if (t >= 65536) return 0;
    k = int'(t >> 11);
    d = exp_lut[k] - exp_lut[k+1];
    return exp_lut[k] - int'((d * (t & 2047) + 1024) >> 11);
  endfunction

  function automatic int eff_in();
    return in_cnt > NIN ? NIN : in_cnt;
  endfunction

  function automatic int eff_out();
    return out_cnt > NOUT ? NOUT : out_cnt;
  endfunction

  function automatic void run_layer();
    int ni;
    int no;
    longint acc;
    longint top;
    longint total;
    ni = eff_in();
    no = eff_out();
    for (int j = 0; j < no; j++) begin
      acc = sat_acc(longint'(biases[j]) * 4096);
      for (int i = 0; i < ni; i++)
        acc = sat_acc(acc + longint'(weights[j*NIN+i]) * longint'(inputs[i]));
      net[j] = to_q12(acc);
    end
    if (no == 0) return;
    if (!softmax_on) begin
      for (int j = 0; j < no; j++) outputs[j] = shortint'(sigmoid_q12(int'(net[j])));
      return;
    end
    top = net[0];
    for (int j = 1; j < no; j++) if (net[j] > top) top = net[j];
    total = 0;
    for (int j = 0; j < no; j++) begin
      expo[j] = exp_neg_q16(top - net[j]);
      total += expo[j];
    end
    for (int j = 0; j < no; j++)
      outputs[j] = shortint'((longint'(expo[j]) * 4096 + total / 2) / total);
  endfunction

  function automatic bit layer_ready(int pos);
    for (int j = 0; j < eff_out(); j++) begin
      if (!bias_set[j]) return 0;
      for (int i = 0; i < eff_in(); i++) if (!weight_set[j*NIN+i]) return 0;
    end
    for (int i = 0; i < eff_in(); i++) if (!(input_set[i] || i == pos)) return 0;
    return 1;
  endfunction

  function automatic void predict_item(logic [OPCODE_W-1:0] op, int nrn, int pos, int dat,
                                       bit fin);
    readout_t r;
    case (op)
      OP_WEIGHT: begin
        weights[nrn*NIN+pos] = shortint'(dat);
        weight_set[nrn*NIN+pos] = 1;
      end
      OP_BIAS: begin
        biases[nrn] = shortint'(dat);
        bias_set[nrn] = 1;
      end
      OP_ACT: begin
        inputs[pos] = shortint'(dat);
        input_set[pos] = 1;
        if (fin) run_layer();
      end
      default: begin
        r.idx = nrn[NEURON_W-1:0];
        r.act = outputs[nrn];
        pending_reads.push_back(r);
      end
    endcase
  endfunction

  function automatic int rand_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic int rand_datum();
    if ($urandom_range(0, 4) == 0) return $urandom_range(0, 65535) - 32768;
    return $urandom_range(0, 4095) - 2048;
  endfunction

  task automatic send_item(input logic [OPCODE_W-1:0] op, input int nrn, input int pos,
                           input int dat, input bit fin);
    int gap;
    gap = rand_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    opcode <= op;
    neuron <= nrn[NEURON_W-1:0];
    position <= pos[POS_W-1:0];
    datum <= dat[15:0];
    final_input <= fin;
    do @(posedge clk); while (in_stall);
    predict_item(op, nrn, pos, dat, fin);
    items_sent++;
  endtask

  // send one more read, then hold the input back until every read has come back and the unit is idle
  task automatic settle();
    send_item(OP_READ, $urandom_range(0, NOUT-1), 0, 0, 1'b0);
    in_valid <= 1'b0;
    while (pending_reads.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val[CFG_DATA_W-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_SOFTMAX: softmax_on = val[0];
      REG_IN_COUNT: in_cnt = val & 11'h7FF;
      default: out_cnt = val & 8'hFF;
    endcase
  endtask

  task automatic send_noise();
    logic [OPCODE_W-1:0] op;
    op = $urandom_range(0, 3);
    send_item(op, $urandom_range(0, NOUT-1), $urandom_range(0, NIN-1), rand_datum(),
              op == OP_ACT ? 1'b0 : 1'($urandom_range(0, 1)));
  endtask

  task automatic test_reset_outputs();
    send_item(OP_READ, 0, 0, 0, 1'b0);
    send_item(OP_READ, NOUT-1, NIN-1, -1, 1'b1);
    settle();
  endtask

  task automatic test_sigmoid_extremes();
    write_reg(REG_SOFTMAX, 0);
    write_reg(REG_IN_COUNT, 2);
    write_reg(REG_OUT_COUNT, 2);
    send_item(OP_WEIGHT, 0, 0, 32767, 1'b1);
    send_item(OP_WEIGHT, 0, 1, 32767, 1'b0);
    send_item(OP_WEIGHT, 1, 0, -32768, 1'b0);
    send_item(OP_WEIGHT, 1, 1, 32767, 1'b0);
    send_item(OP_BIAS, 0, 0, 32767, 1'b1);
    send_item(OP_BIAS, 1, NIN-1, -32768, 1'b0);
    send_item(OP_ACT, 0, 0, 32767, 1'b0);
    send_item(OP_ACT, 0, 1, -32768, 1'b1);
    send_item(OP_READ, 0, 0, 0, 1'b0);
    send_item(OP_READ, 1, 0, 0, 1'b0);
    send_item(OP_READ, 5, 0, 0, 1'b0);
    settle();
  endtask

  task automatic test_softmax_pair();
    write_reg(REG_SOFTMAX, 1);
    send_item(OP_ACT, 0, 1, 1000, 1'b1);
    send_item(OP_READ, 0, 0, 0, 1'b0);
    send_item(OP_READ, 1, 0, 0, 1'b0);
    settle();
  endtask

  task automatic test_zero_counts();
    write_reg(REG_SOFTMAX, 0);
    write_reg(REG_IN_COUNT, 0);
    send_item(OP_ACT, 0, 7, 123, 1'b1);
    send_item(OP_READ, 1, 0, 0, 1'b0);
    settle();
    write_reg(REG_OUT_COUNT, 0);
    send_item(OP_BIAS, 0, 0, -4096, 1'b0);
    send_item(OP_ACT, 0, 9, 55, 1'b1);
    send_item(OP_READ, 0, 0, 0, 1'b0);
    settle();
  endtask

  task automatic test_full_sizes();
    write_reg(REG_IN_COUNT, 2047);
    write_reg(REG_OUT_COUNT, 1);
    for (int i = 0; i < NIN; i++) send_item(OP_WEIGHT, 0, i, rand_datum() >>> 3, 1'b0);
    for (int i = 0; i < NIN; i++) send_item(OP_ACT, 0, i, rand_datum() >>> 3, i == NIN-1);
    send_item(OP_READ, 0, 0, 0, 1'b0);
    settle();
    write_reg(REG_SOFTMAX, 1);
    write_reg(REG_IN_COUNT, NIN);
    send_item(OP_ACT, 0, 3, rand_datum(), 1'b1);
    send_item(OP_READ, 0, 0, 0, 1'b0);
    settle();
    write_reg(REG_IN_COUNT, 1);
    write_reg(REG_OUT_COUNT, 255);
    for (int j = 0; j < NOUT; j++) begin
      send_item(OP_BIAS, j, 0, rand_datum(), 1'b0);
      send_item(OP_WEIGHT, j, 0, rand_datum(), 1'b0);
    end
    send_item(OP_ACT, 0, 0, rand_datum(), 1'b1);
    for (int j = 0; j < 8; j++) send_item(OP_READ, $urandom_range(0, NOUT-1), 0, 0, 1'b0);
    send_item(OP_READ, NOUT-1, 0, 0, 1'b0);
    settle();
    write_reg(REG_SOFTMAX, 0);
    write_reg(REG_OUT_COUNT, NOUT);
    send_item(OP_ACT, 0, 0, rand_datum(), 1'b1);
    send_item(OP_READ, 0, 0, 0, 1'b0);
    send_item(OP_READ, NOUT-1, 0, 0, 1'b0);
    settle();
  endtask

  task automatic test_random_layers();
    int nin;
    int nout;
    int pos;
    int phase;
    bit fresh;
    phase = 0;
    while (items_sent < TARGET_ITEMS || phase < 3) begin
      no_idle = (phase % 6 == 1);
      nin = $urandom_range(0, 19) == 0 ? 0 : $urandom_range(1, 24);
      nout = $urandom_range(0, 19) == 0 ? 0 : $urandom_range(1, 10);
      write_reg(REG_SOFTMAX, $urandom_range(0, 1));
      write_reg(REG_IN_COUNT, nin);
      write_reg(REG_OUT_COUNT, nout);
      fresh = $urandom_range(0, 4) != 0;
      for (int j = 0; j < nout; j++) begin
        if (fresh || !bias_set[j]) send_item(OP_BIAS, j, $urandom_range(0, NIN-1),
                                             rand_datum(), 1'($urandom_range(0, 1)));
        for (int i = 0; i < nin; i++) begin
          if (fresh || !weight_set[j*NIN+i]) send_item(OP_WEIGHT, j, i, rand_datum(), 1'b0);
          if ($urandom_range(0, 99) < 8) send_noise();
        end
      end
      for (int i = 0; i < nin; i++) begin
        send_item(OP_ACT, $urandom_range(0, NOUT-1), i, rand_datum(),
                  i == nin-1 && layer_ready(i));
        if (i != nin-1 && $urandom_range(0, 99) < 8) send_noise();
      end
      if (nin == 0) begin
        pos = $urandom_range(0, NIN-1);
        send_item(OP_ACT, 0, pos, rand_datum(), layer_ready(pos));
      end
      for (int j = 0; j < nout; j++) send_item(OP_READ, j, $urandom_range(0, NIN-1), 0, 1'b0);
      send_item(OP_READ, $urandom_range(0, NOUT-1), 0, 0, 1'b0);
      settle();
      phase++;
    end
    no_idle = 0;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      out_hold <= 0;
    end else if (out_hold != 0) begin
      out_hold <= out_hold - 1;
    end else begin
      out_stall <= !no_idle && $urandom_range(0, 2) == 0;
      out_hold <= $urandom_range(0, 9) == 0 ? $urandom_range(10, 40) : $urandom_range(0, 3);
    end
  end

  always @(posedge clk) begin
    readout_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_reads.size() == 0) begin
        $display("%0t unexpected result: index %0d activation %0d", $time, out_index,
                 activation);
        errors++;
      end else begin
        want = pending_reads.pop_front();
        if (out_index !== want.idx) begin
          $display("%0t out_index: expected %0d actual %0d", $time, want.idx, out_index);
          errors++;
        end
        if (activation !== want.act) begin
          $display("%0t activation (index %0d): expected %0d actual %0d", $time, want.idx,
                   want.act, activation);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCH_LIMIT) begin
      $display("FAIL dense_layer_forward_unit");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    clk = 1'b0;
    rst <= 1'b1;
    cfg_we <= 1'b0;
    cfg_index <= REG_SOFTMAX;
    cfg_data <= '0;
    in_valid <= 1'b0;
    opcode <= OP_READ;
    neuron <= '0;
    position <= '0;
    datum <= '0;
    final_input <= 1'b0;
    softmax_on = 0;
    in_cnt = IN_COUNT_RST;
    out_cnt = OUT_COUNT_RST;
    errors = 0;
    items_sent = 0;
    no_idle = 0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_outputs();
    test_sigmoid_extremes();
    test_softmax_pair();
    test_zero_counts();
    test_full_sizes();
    test_random_layers();
    repeat (20) @(posedge clk);
    if (errors == 0 && pending_reads.size() == 0) begin
      $display("PASS dense_layer_forward_unit");
    end else begin
      $display("FAIL dense_layer_forward_unit");
    end
    $finish;
  end

endmodule
